FILE: hw/rtl/kese_pkg.sv
// ----------------------------------------------------------------------------
// kese_pkg: shared types and constants of the key escape sequence encoder
// Holds the token format that travels from the classifier to the byte
// sequencer, the queue entry, the character codes and the decimal weights.
// ----------------------------------------------------------------------------
package kese_pkg;

  localparam int unsigned TokMax     = 10;
  localparam int unsigned TokIdxW    = $clog2(TokMax);
  localparam int unsigned TokCntW    = $clog2(TokMax + 1);
  localparam int unsigned DecValW    = 21;
  localparam int unsigned DecWeightW = 24;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxTextBytes = 4;

  // Character codes.
  localparam logic [7:0] ChEsc   = 8'd27;
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChDel   = 8'd127;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChThree = 8'h33;

  // One output token: a literal byte, or a number printed in decimal
  // starting from digit position top_digit.
  typedef struct packed {
    logic               is_dec;
    logic [2:0]         top_digit;
    logic [DecValW-1:0] value;
  } kese_tok_t;

  typedef struct packed {
    kese_tok_t [TokMax-1:0] toks;
    logic [TokCntW-1:0]     cnt;
  } kese_entry_t;

  // Weight d * 10^k of a decimal digit.
  function automatic logic [DecWeightW-1:0] dec_weight(input logic [2:0] k,
                                                      input logic [3:0] d);
    logic [DecWeightW-1:0] pw;
    logic [DecWeightW+3:0] prod;
    case (k)
      3'd0:    pw = 24'd1;
      3'd1:    pw = 24'd10;
      3'd2:    pw = 24'd100;
      3'd3:    pw = 24'd1000;
      3'd4:    pw = 24'd10000;
      3'd5:    pw = 24'd100000;
      3'd6:    pw = 24'd1000000;
      default: pw = 24'd0;
    endcase
    prod = {4'd0, pw} * {24'd0, d};
    return prod[DecWeightW-1:0];
  endfunction

endpackage

FILE: hw/rtl/keystroke_escape_sequence_encoder.sv
// ----------------------------------------------------------------------------
// keystroke_escape_sequence_encoder: terminal key escape sequence encoder
// Converts key events into the byte stream a terminal sends, in legacy
// xterm-style encoding or in the progressive CSI ... u protocol.
// ----------------------------------------------------------------------------
// Each accepted key request produces zero to nineteen bytes on the output
// channel, one byte per transfer, with last_byte_o set on the final byte.
// The classifier takes a key request in every cycle while its two-entry
// queue has room; keys that send nothing are dropped there. The sequencer
// emits one byte per cycle for literal characters while the output is not
// stalled, and prints numbers one decimal digit at a time with leading zero
// digits skipped silently; it loads the next key from the queue between
// sequences. Registers sit on the APB port: protocol_flags at byte address 0
// and app_cursor_mode at byte address 4. Write them only while the block is
// idle.
// ----------------------------------------------------------------------------
module keystroke_escape_sequence_encoder import kese_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Key request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [28:0] key_symbol_i,
  input  logic [3:0]  modifier_mask_i,
  input  logic [2:0]  text_length_i,
  input  logic [7:0]  text_byte_0_i,
  input  logic [7:0]  text_byte_1_i,
  input  logic [7:0]  text_byte_2_i,
  input  logic [7:0]  text_byte_3_i,
  input  logic        is_press_i,
  // Byte output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  // Register select is address bit 2; the low bits are ignored.
  localparam logic RegProtoFlags = 1'b0;
  localparam logic RegAppCursor  = 1'b1;

  logic [4:0]  protocol_flags_q;
  logic        app_cursor_mode_q;
  logic        cfg_write;

  logic        has_bytes;
  kese_entry_t entry;
  logic        q_full;
  logic        q_pop;
  logic        q_not_empty;
  kese_entry_t q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_flags_q  <= '0;
      app_cursor_mode_q <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == RegProtoFlags) protocol_flags_q <= pwdata[4:0];
      if (paddr[2] == RegAppCursor)  app_cursor_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    if (paddr[2] == RegAppCursor) prdata = {31'd0, app_cursor_mode_q};
    else prdata = {27'd0, protocol_flags_q};
  end

  // The classifier works in the same cycle as the request; the queue takes
  // the token list only when the key sends at least one byte.
  assign in_ready_o = !q_full;

  kese_front u_front (
    .protocol_flags_i (protocol_flags_q),
    .app_cursor_mode_i(app_cursor_mode_q),
    .key_symbol_i     (key_symbol_i),
    .modifier_mask_i  (modifier_mask_i),
    .text_length_i    (text_length_i),
    .text_byte_0_i    (text_byte_0_i),
    .text_byte_1_i    (text_byte_1_i),
    .text_byte_2_i    (text_byte_2_i),
    .text_byte_3_i    (text_byte_3_i),
    .is_press_i       (is_press_i),
    .has_bytes_o      (has_bytes),
    .entry_o          (entry)
  );

  kese_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && in_ready_o && has_bytes),
    .push_data_i(entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .not_empty_o(q_not_empty),
    .head_o     (q_head)
  );

  kese_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_not_empty_i(q_not_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

FILE: hw/rtl/kese_front.sv
// ----------------------------------------------------------------------------
// kese_front: key event classifier
// Turns one key event into a short token list for the byte sequencer.
// ----------------------------------------------------------------------------
module kese_front import kese_pkg::*; (
  input  logic [4:0]  protocol_flags_i,
  input  logic        app_cursor_mode_i,
  input  logic [28:0] key_symbol_i,
  input  logic [3:0]  modifier_mask_i,
  input  logic [2:0]  text_length_i,
  input  logic [7:0]  text_byte_0_i,
  input  logic [7:0]  text_byte_1_i,
  input  logic [7:0]  text_byte_2_i,
  input  logic [7:0]  text_byte_3_i,
  input  logic        is_press_i,
  output logic        has_bytes_o,
  output kese_entry_t entry_o
);

  localparam logic [28:0] KsLeftTab = 29'hfe20;
  localparam logic [28:0] KsBackspc = 29'hff08;
  localparam logic [28:0] KsTab     = 29'hff09;
  localparam logic [28:0] KsReturn  = 29'hff0d;
  localparam logic [28:0] KsEscape  = 29'hff1b;

  typedef struct packed {
    logic [4:0] num;
    logic [7:0] fin;
  } fkey_t;

  function automatic fkey_t fkey(input logic [28:0] s);
    fkey_t r;
    case (s)
      29'hff52: r = '{5'd1, 8'h41};
      29'hff54: r = '{5'd1, 8'h42};
      29'hff53: r = '{5'd1, 8'h43};
      29'hff51: r = '{5'd1, 8'h44};
      29'hff50: r = '{5'd1, 8'h48};
      29'hff57: r = '{5'd1, 8'h46};
      29'hff63: r = '{5'd2, ChTilde};
      29'hffff: r = '{5'd3, ChTilde};
      29'hff55: r = '{5'd5, ChTilde};
      29'hff56: r = '{5'd6, ChTilde};
      29'hffbe: r = '{5'd1, 8'h50};
      29'hffbf: r = '{5'd1, 8'h51};
      29'hffc0: r = '{5'd1, 8'h52};
      29'hffc1: r = '{5'd1, 8'h53};
      29'hffc2: r = '{5'd15, ChTilde};
      29'hffc3: r = '{5'd17, ChTilde};
      29'hffc4: r = '{5'd18, ChTilde};
      29'hffc5: r = '{5'd19, ChTilde};
      29'hffc6: r = '{5'd20, ChTilde};
      29'hffc7: r = '{5'd21, ChTilde};
      29'hffc8: r = '{5'd23, ChTilde};
      29'hffc9: r = '{5'd24, ChTilde};
      default:  r = '{5'd0, 8'h00};
    endcase
    return r;
  endfunction

  function automatic logic [DecValW-1:0] first_cp(input logic [7:0] t0, input logic [7:0] t1,
                                                  input logic [7:0] t2, input logic [7:0] t3,
                                                  input logic [2:0] n);
    logic [DecValW-1:0] cp;
    cp = '0;
    if (n == 3'd0) begin
      cp = '0;
    end else if (!t0[7]) begin
      cp = {14'd0, t0[6:0]};
    end else if (t0[7:5] == 3'b110) begin
      if (n >= 3'd2 && t1[7:6] == 2'b10) cp = {10'd0, t0[4:0], t1[5:0]};
    end else if (t0[7:4] == 4'b1110) begin
      if (n >= 3'd3 && t1[7:6] == 2'b10 && t2[7:6] == 2'b10) begin
        cp = {5'd0, t0[3:0], t1[5:0], t2[5:0]};
      end
    end else if (t0[7:3] == 5'b11110) begin
      if (n >= 3'd4 && t1[7:6] == 2'b10 && t2[7:6] == 2'b10 && t3[7:6] == 2'b10) begin
        cp = {t0[2:0], t1[5:0], t2[5:0], t3[5:0]};
      end
    end
    return cp;
  endfunction

  function automatic kese_tok_t lit(input logic [7:0] b);
    return '{1'b0, 3'd0, {13'd0, b}};
  endfunction

  function automatic kese_tok_t dec(input logic [DecValW-1:0] v, input logic [2:0] k);
    return '{1'b1, k, v};
  endfunction

  logic [7:0]         tb [4];
  logic [2:0]         n;
  fkey_t              fk;
  logic               ss3;
  logic [4:0]         mplus;
  logic [7:0]         pcode;
  logic [7:0]         pnum;
  logic [7:0]         pfin;
  logic [DecValW-1:0] cp;
  logic               is_letter;
  kese_tok_t [TokMax-1:0] toks;
  logic [TokCntW-1:0] cnt;

  always_comb begin
    tb[0] = text_byte_0_i;
    tb[1] = text_byte_1_i;
    tb[2] = text_byte_2_i;
    tb[3] = text_byte_3_i;
    n = (text_length_i > 3'(MaxTextBytes)) ? 3'(MaxTextBytes) : text_length_i;
    fk = fkey(key_symbol_i);
    mplus = {1'b0, modifier_mask_i} + 5'd1;
    ss3 = (fk.num == 5'd1) &&
          ((fk.fin >= 8'h50 && fk.fin <= 8'h53) ||
           (app_cursor_mode_i && fk.fin != ChTilde));
    is_letter = (key_symbol_i >= 29'h61 && key_symbol_i <= 29'h7a) ||
                (key_symbol_i >= 29'h41 && key_symbol_i <= 29'h5a);

    case (key_symbol_i)
      KsEscape:  pcode = ChEsc;
      KsReturn:  pcode = 8'd13;
      KsTab:     pcode = 8'd9;
      KsLeftTab: pcode = 8'd9;
      KsBackspc: pcode = ChDel;
      default: begin
        if (key_symbol_i >= 29'h20 && key_symbol_i < 29'h7f) pcode = key_symbol_i[7:0];
        else if (n != 3'd0) pcode = tb[0];
        else pcode = 8'd0;
      end
    endcase
    pnum = (fk.num != 5'd0) ? {3'd0, fk.num} : pcode;
    pfin = (fk.num != 5'd0) ? fk.fin : ChU;
    cp = '0;
    if (protocol_flags_i[4] && is_press_i && pfin == ChU) begin
      cp = first_cp(tb[0], tb[1], tb[2], tb[3], n);
    end

    toks = '0;
    cnt  = '0;
    if (protocol_flags_i == 5'd0) begin
      if (!is_press_i) begin
        cnt = '0;
      end else if (key_symbol_i == KsLeftTab) begin
        toks[0] = lit(ChEsc); toks[1] = lit(ChLbr); toks[2] = lit(ChZ);
        cnt = 4'd3;
      end else if (modifier_mask_i[2] && is_letter) begin
        toks[0] = lit({3'd0, key_symbol_i[4:0]});
        cnt = 4'd1;
      end else if (fk.num != 5'd0) begin
        toks[0] = lit(ChEsc);
        if (modifier_mask_i == 4'd0) begin
          if (fk.fin == ChTilde) begin
            toks[1] = lit(ChLbr); toks[2] = dec({16'd0, fk.num}, 3'd1);
            toks[3] = lit(ChTilde);
            cnt = 4'd4;
          end else begin
            toks[1] = lit(ss3 ? ChO : ChLbr); toks[2] = lit(fk.fin);
            cnt = 4'd3;
          end
        end else begin
          toks[1] = lit(ChLbr); toks[2] = dec({16'd0, fk.num}, 3'd1);
          toks[3] = lit(ChSemi); toks[4] = dec({16'd0, mplus}, 3'd1);
          toks[5] = lit(fk.fin);
          cnt = 4'd6;
        end
      end else if (key_symbol_i == KsBackspc || key_symbol_i == KsEscape || n != 3'd0) begin
        if (modifier_mask_i[1]) begin
          toks[cnt[TokIdxW-1:0]] = lit(ChEsc);
          cnt = cnt + 4'd1;
        end
        if (key_symbol_i == KsBackspc) begin
          toks[cnt[TokIdxW-1:0]] = lit(modifier_mask_i[2] ? ChBs : ChDel);
          cnt = cnt + 4'd1;
        end else if (key_symbol_i == KsEscape) begin
          toks[cnt[TokIdxW-1:0]] = lit(ChEsc);
          cnt = cnt + 4'd1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < n) begin
              toks[cnt[TokIdxW-1:0]] = lit(tb[i]);
              cnt = cnt + 4'd1;
            end
          end
        end
      end
    end else if (pnum != 8'd0) begin
      toks[0] = lit(ChEsc);
      toks[1] = lit(ChLbr);
      if (cp != '0) begin
        toks[2] = dec({13'd0, pnum}, 3'd2); toks[3] = lit(ChSemi);
        toks[4] = dec({16'd0, mplus}, 3'd1); toks[5] = lit(ChColon);
        toks[6] = lit(is_press_i ? ChOne : ChThree); toks[7] = lit(ChSemi);
        toks[8] = dec(cp, 3'd6); toks[9] = lit(ChU);
        cnt = 4'd10;
      end else if (mplus == 5'd1 && is_press_i) begin
        if (pfin == ChU || pfin == ChTilde) begin
          toks[2] = dec({13'd0, pnum}, 3'd2); toks[3] = lit(pfin);
          cnt = 4'd4;
        end else begin
          toks[1] = lit(ss3 ? ChO : ChLbr); toks[2] = lit(pfin);
          cnt = 4'd3;
        end
      end else if (is_press_i) begin
        toks[2] = dec({13'd0, pnum}, 3'd2); toks[3] = lit(ChSemi);
        toks[4] = dec({16'd0, mplus}, 3'd1); toks[5] = lit(pfin);
        cnt = 4'd6;
      end else begin
        toks[2] = dec({13'd0, pnum}, 3'd2); toks[3] = lit(ChSemi);
        toks[4] = dec({16'd0, mplus}, 3'd1); toks[5] = lit(ChColon);
        toks[6] = lit(ChThree); toks[7] = lit(pfin);
        cnt = 4'd8;
      end
    end
  end

  assign entry_o.toks = toks;
  assign entry_o.cnt  = cnt;
  assign has_bytes_o  = (cnt != '0);

endmodule

FILE: hw/rtl/kese_queue.sv
// ----------------------------------------------------------------------------
// kese_queue: short request queue between classifier and sequencer
// Two-entry register queue of token lists.
// ----------------------------------------------------------------------------
module kese_queue import kese_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  kese_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        not_empty_o,
  output kese_entry_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  kese_entry_t        slot_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  assign full_o      = (count_q == (PtrW+1)'(QueueDepth));
  assign not_empty_o = (count_q != '0);
  assign head_o      = slot_q[rd_ptr_q];

endmodule

FILE: hw/rtl/kese_back.sv
// ----------------------------------------------------------------------------
// kese_back: byte sequencer
// Walks a token list and streams one byte per cycle unless the output stalls;
// numbers are printed one decimal digit per cycle with leading zeros skipped.
// ----------------------------------------------------------------------------
module kese_back import kese_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_not_empty_i,
  input  kese_entry_t q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o
);

  logic               busy_q;
  kese_entry_t        entry_q;
  logic [TokIdxW-1:0] idx_q;
  logic               dec_live_q;
  logic               seen_q;
  logic [2:0]         dig_k_q;
  logic [DecValW-1:0] rem_q;
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q;

  kese_tok_t          tok;
  logic               can_emit;
  logic               last_tok;
  logic [DecValW-1:0] r;
  logic [2:0]         k;
  logic [3:0]         digit;
  logic [DecWeightW-1:0] sub;
  logic               emit;
  logic               tok_done;
  logic [7:0]         byte_val;

  assign can_emit = !out_valid_q || out_ready_i;
  assign q_pop_o  = !busy_q && q_not_empty_i;
  assign tok      = entry_q.toks[idx_q];
  assign last_tok = (idx_q == TokIdxW'(entry_q.cnt - 1'b1));

  always_comb begin
    r     = dec_live_q ? rem_q : tok.value;
    k     = dec_live_q ? dig_k_q : tok.top_digit;
    digit = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if ({3'd0, r} >= dec_weight(k, 4'(j))) digit = 4'(j);
    end
    sub = dec_weight(k, digit);
    if (tok.is_dec) begin
      tok_done = (k == 3'd0);
      emit     = seen_q || digit != 4'd0 || k == 3'd0;
      byte_val = ChZero + {4'd0, digit};
    end else begin
      tok_done = 1'b1;
      emit     = 1'b1;
      byte_val = tok.value[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      dec_live_q  <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q     <= 1'b1;
        idx_q      <= '0;
        dec_live_q <= 1'b0;
        seen_q     <= 1'b0;
      end
      if (can_emit) begin
        out_valid_q <= busy_q && emit;
        if (busy_q) begin
          if (tok_done) begin
            dec_live_q <= 1'b0;
            seen_q     <= 1'b0;
            idx_q      <= idx_q + 1'b1;
            if (last_tok) busy_q <= 1'b0;
          end else begin
            dec_live_q <= 1'b1;
            seen_q     <= seen_q || digit != 4'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) entry_q <= q_head_i;
    if (can_emit && busy_q) begin
      rem_q      <= r - sub[DecValW-1:0];
      dig_k_q    <= k - 3'd1;
      out_byte_q <= byte_val;
      out_last_q <= last_tok && tok_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> entry_q.cnt != '0)
    else $error("sequencer holds an empty token list");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q < entry_q.cnt)
    else $error("token index past end of list");

  a_hold_stalled_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=>
      out_valid_q && $stable(out_byte_q) && $stable(out_last_q))
    else $error("stalled output byte changed before it was taken");

endmodule

FILE: dv/keystroke_escape_sequence_encoder_tb.sv
// ----------------------------------------------------------------------------
// keystroke_escape_sequence_encoder_tb: self-checking key encoder testbench
// Drives key requests through the encoder in legacy and progressive protocol
// settings. Every output byte is checked against a byte predictor in order.
// ----------------------------------------------------------------------------
module keystroke_escape_sequence_encoder_tb;
  import kese_pkg::*;

  // Register byte addresses on the APB port.
  localparam logic [2:0] AddrProtocolFlags = 3'd0;
  localparam logic [2:0] AddrAppCursor     = 3'd4;
  localparam int unsigned FlagAssocText    = 16;
  localparam int unsigned ModAlt           = 2;
  localparam int unsigned ModCtrl          = 4;
  localparam int unsigned CycleLimit       = 400000;

  // Keysyms that get special treatment.
  localparam int unsigned KsIsoLeftTab = 'hfe20;
  localparam int unsigned KsBackspace  = 'hff08;
  localparam int unsigned KsTab        = 'hff09;
  localparam int unsigned KsReturn     = 'hff0d;
  localparam int unsigned KsEscape     = 'hff1b;

  typedef struct packed {
    logic [28:0] sym;
    logic [3:0]  mods;
    logic [2:0]  len;
    logic [7:0]  t0, t1, t2, t3;
    logic        press;
  } key_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } key_byte_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  key_req_t cur_req;
  logic out_valid_o, out_ready_i;
  logic [7:0] out_byte_o;
  logic last_byte_o;

  key_req_t  pending_keys[$];
  key_byte_t expected_bytes[$];
  logic [7:0] seq_bytes[$];

  // The predictor's own copy of the two registers.
  int unsigned flags_shadow, cursor_shadow;
  int unsigned errors, cycles;
  int unsigned burst_left, gap_left, hold_off;

  keystroke_escape_sequence_encoder u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .key_symbol_i(cur_req.sym), .modifier_mask_i(cur_req.mods),
    .text_length_i(cur_req.len), .text_byte_0_i(cur_req.t0),
    .text_byte_1_i(cur_req.t1), .text_byte_2_i(cur_req.t2),
    .text_byte_3_i(cur_req.t3), .is_press_i(cur_req.press),
    .out_valid_o, .out_ready_i, .out_byte_o, .last_byte_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers. Each builds the byte sequence of one key in seq_bytes.
  // ---------------------------------------------------------------------------
  function automatic void put_decimal(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(48 + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) seq_bytes.push_back(digits[i]);
  endfunction

  // Cursor, navigation and F-key table: number parameter and final character.
  function automatic int unsigned nav_key_code(int unsigned sym, output logic [7:0] fin);
    fin = "~";
    case (sym)
      'hff52: begin fin = "A"; return 1; end
      'hff54: begin fin = "B"; return 1; end
      'hff53: begin fin = "C"; return 1; end
      'hff51: begin fin = "D"; return 1; end
      'hff50: begin fin = "H"; return 1; end
      'hff57: begin fin = "F"; return 1; end
      'hff63: return 2;
      'hffff: return 3;
      'hff55: return 5;
      'hff56: return 6;
      'hffbe: begin fin = "P"; return 1; end
      'hffbf: begin fin = "Q"; return 1; end
      'hffc0: begin fin = "R"; return 1; end
      'hffc1: begin fin = "S"; return 1; end
      'hffc2: return 15;
      'hffc3: return 17;
      'hffc4: return 18;
      'hffc5: return 19;
      'hffc6: return 20;
      'hffc7: return 21;
      'hffc8: return 23;
      'hffc9: return 24;
      default: begin fin = 0; return 0; end
    endcase
  endfunction

  function automatic bit uses_ss3(int unsigned num, logic [7:0] fin);
    if (num != 1) return 0;
    if (fin >= "P" && fin <= "S") return 1;
    if (cursor_shadow[0])
      return fin inside {"A", "B", "C", "D", "H", "F"};
    return 0;
  endfunction

  // Decodes the first UTF-8 codepoint; zero means malformed or absent.
  function automatic int unsigned utf8_codepoint(logic [7:0] t[4], int unsigned n);
    int unsigned need, cp;
    if (n == 0) return 0;
    if (t[0] < 8'h80) return t[0];
    else if ((t[0] & 8'hE0) == 8'hC0) begin need = 1; cp = t[0] & 8'h1F; end
    else if ((t[0] & 8'hF0) == 8'hE0) begin need = 2; cp = t[0] & 8'h0F; end
    else if ((t[0] & 8'hF8) == 8'hF0) begin need = 3; cp = t[0] & 8'h07; end
    else return 0;
    if (n < need + 1) return 0;
    for (int i = 1; i <= need; i++) begin
      if ((t[i] & 8'hC0) != 8'h80) return 0;
      cp = (cp << 6) | (t[i] & 8'h3F);
    end
    return cp;
  endfunction

  function automatic void encode_legacy_key(int unsigned sym, int unsigned mods,
                                            logic [7:0] t[4], int unsigned n);
    logic [7:0] fin;
    int unsigned num;
    bit special;
    logic [7:0] code;
    special = 0;
    code = 0;
    if (sym == KsIsoLeftTab) begin
      seq_bytes = '{ChEsc, ChLbr, ChZ};
      return;
    end
    if ((mods & ModCtrl) && ((sym >= "a" && sym <= "z") || (sym >= "A" && sym <= "Z"))) begin
      seq_bytes.push_back(8'((sym | 'h20) - "a" + 1));
      return;
    end
    num = nav_key_code(sym, fin);
    if (num != 0) begin
      seq_bytes.push_back(ChEsc);
      if (mods == 0) begin
        if (fin == ChTilde) begin
          seq_bytes.push_back(ChLbr); put_decimal(num); seq_bytes.push_back(ChTilde);
        end else if (uses_ss3(num, fin)) begin
          seq_bytes.push_back(ChO); seq_bytes.push_back(fin);
        end else begin
          seq_bytes.push_back(ChLbr); seq_bytes.push_back(fin);
        end
      end else begin
        seq_bytes.push_back(ChLbr); put_decimal(num); seq_bytes.push_back(ChSemi);
        put_decimal(mods + 1); seq_bytes.push_back(fin);
      end
      return;
    end
    if (sym == KsBackspace) begin
      code = (mods & ModCtrl) ? ChBs : ChDel;
      special = 1;
    end else if (sym == KsEscape) begin
      code = ChEsc;
      special = 1;
    end
    if (!special && n == 0) return;
    if (mods & ModAlt) seq_bytes.push_back(ChEsc);
    if (special) seq_bytes.push_back(code);
    else for (int i = 0; i < n; i++) seq_bytes.push_back(t[i]);
  endfunction

  function automatic void encode_protocol_key(int unsigned sym, int unsigned mods,
                                              logic [7:0] t[4], int unsigned n,
                                              bit press);
    int unsigned m, evt, num, cp;
    logic [7:0] fin;
    m = mods + 1;
    evt = press ? 1 : 3;
    cp = 0;
    num = nav_key_code(sym, fin);
    if (num == 0) begin
      fin = ChU;
      case (sym)
        KsEscape: num = 27;
        KsReturn: num = 13;
        KsTab, KsIsoLeftTab: num = 9;
        KsBackspace: num = 127;
        default: begin
          if (sym >= 'h20 && sym < 'h7f) num = sym;
          else if (n > 0) num = t[0];
        end
      endcase
      if (num == 0) return;
    end
    if ((flags_shadow & FlagAssocText) && press && n > 0 && fin == ChU)
      cp = utf8_codepoint(t, n);
    seq_bytes.push_back(ChEsc);
    if (cp != 0) begin
      seq_bytes.push_back(ChLbr); put_decimal(num); seq_bytes.push_back(ChSemi);
      put_decimal(m); seq_bytes.push_back(ChColon); put_decimal(evt);
      seq_bytes.push_back(ChSemi); put_decimal(cp); seq_bytes.push_back(ChU);
    end else if (m == 1 && evt == 1) begin
      if (fin == ChU || fin == ChTilde) begin
        seq_bytes.push_back(ChLbr); put_decimal(num); seq_bytes.push_back(fin);
      end else if (uses_ss3(num, fin)) begin
        seq_bytes.push_back(ChO); seq_bytes.push_back(fin);
      end else begin
        seq_bytes.push_back(ChLbr); seq_bytes.push_back(fin);
      end
    end else begin
      seq_bytes.push_back(ChLbr); put_decimal(num); seq_bytes.push_back(ChSemi);
      put_decimal(m);
      if (evt != 1) begin
        seq_bytes.push_back(ChColon); put_decimal(evt);
      end
      seq_bytes.push_back(fin);
    end
  endfunction

  // Appends the expected bytes of one accepted key request.
  function automatic void predict_key_bytes(key_req_t r);
    logic [7:0] t[4];
    int unsigned n;
    t = '{r.t0, r.t1, r.t2, r.t3};
    n = (r.len > MaxTextBytes) ? MaxTextBytes : r.len;
    seq_bytes.delete();
    if (flags_shadow == 0) begin
      if (r.press) encode_legacy_key(r.sym, r.mods, t, n);
    end else begin
      encode_protocol_key(r.sym, r.mods, t, n, r.press);
    end
    foreach (seq_bytes[i])
      expected_bytes.push_back('{data: seq_bytes[i], last: (i == seq_bytes.size() - 1)});
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. Valid
  // stays high with a steady payload until the request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cur_req    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_key_bytes(cur_req);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_keys.size() != 0) begin
          cur_req    <= pending_keys.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(12, 1);
            gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte monitor with its own stall pattern. hold_off forces one long stall so
  // the encoder queue fills and pushes back on the request side.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      cycles      <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
        end else begin
          key_byte_t exp_b;
          exp_b = expected_bytes.pop_front();
          if (out_byte_o !== exp_b.data)
            report_mismatch($sformatf("byte %02h, wanted %02h", out_byte_o, exp_b.data));
          if (last_byte_o !== exp_b.last)
            report_mismatch($sformatf("last %b, wanted %b", last_byte_o, exp_b.last));
        end
      end
      if (hold_off != 0) begin
        hold_off    <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(3, 0) != 0);
      end
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // APB write: setup cycle then access cycle.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrProtocolFlags) flags_shadow = data & 'h1f;
    else cursor_shadow = data & 1;
  endtask

  // Waits until every queued request is taken and every byte has arrived,
  // then lets the pipeline settle for dropped keys still in flight.
  task automatic drain_encoder();
    while (pending_keys.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic key_req_t make_key(int unsigned sym, int unsigned mods,
                                        int unsigned len, logic [31:0] text, bit press);
    return '{sym: 29'(sym), mods: 4'(mods), len: 3'(len), t0: text[7:0], t1: text[15:8],
             t2: text[23:16], t3: text[31:24], press: press};
  endfunction

  // Random key with weighting toward keys that reach the interesting paths.
  function automatic key_req_t random_key();
    key_req_t r;
    int unsigned pick;
    int unsigned named_keys[10];
    named_keys = '{KsIsoLeftTab, KsBackspace, KsTab, KsReturn, KsEscape,
                   'hff52, 'hff50, 'hffff, 'hffbe, 'hffc9};
    r = key_req_t'($bits(key_req_t)'({$urandom, $urandom, $urandom}));
    r.len = 3'($urandom_range(4, 0));
    if ($urandom_range(9, 0) == 0) r.len = 3'($urandom_range(7, 5));
    pick = $urandom_range(9, 0);
    case (pick)
      0, 1:    r.sym = 29'(named_keys[$urandom_range(9, 0)]);
      2:       r.sym = 29'('hff50 + $urandom_range(15, 0));
      3:       r.sym = 29'('hffbe + $urandom_range(11, 0));
      4, 5:    r.sym = 29'($urandom_range('h7e, 'h20));
      6: begin
        // UTF-8 text with valid lead and continuation bytes on a non-printing keysym.
        r.sym = 29'($urandom_range('h10ffff, 'h100));
        r.len = 3'($urandom_range(4, 2));
        r.t0 = (r.len == 2) ? 8'(8'hC2 | ($urandom & 8'h1d)) :
               (r.len == 3) ? 8'(8'hE0 | ($urandom & 8'h0f)) : 8'(8'hF0 | ($urandom & 8'h07));
        r.t1 = 8'(8'h80 | ($urandom & 8'h3f));
        r.t2 = 8'(8'h80 | ($urandom & 8'h3f));
        r.t3 = 8'(8'h80 | ($urandom & 8'h3f));
      end
      7:       r.sym = 29'($urandom & 'hffff);
      default: r.sym = 29'($urandom);
    endcase
    r.press = ($urandom_range(3, 0) != 0);
    return r;
  endfunction

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    flags_shadow = 0; cursor_shadow = 0; errors = 0; hold_off = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys in legacy mode with reset register values.
    pending_keys.push_back(make_key(KsIsoLeftTab, 0, 0, 0, 1));     // back-tab
    pending_keys.push_back(make_key("c", ModCtrl, 1, "c", 1));      // ctrl letter
    pending_keys.push_back(make_key("Z", ModCtrl | ModAlt, 1, "Z", 1));
    pending_keys.push_back(make_key('hff52, 0, 0, 0, 1));           // plain arrow
    pending_keys.push_back(make_key('hff52, 15, 0, 0, 1));          // all modifiers
    pending_keys.push_back(make_key('hffc9, 0, 0, 0, 1));           // F12
    pending_keys.push_back(make_key('hffbe, 0, 0, 0, 1));           // F1 as SS3
    pending_keys.push_back(make_key(KsBackspace, ModCtrl, 0, 0, 1));
    pending_keys.push_back(make_key(KsBackspace, ModAlt, 0, 0, 1));
    pending_keys.push_back(make_key(KsEscape, 0, 0, 0, 1));
    pending_keys.push_back(make_key('h61, ModAlt, 7, 32'hffffff61, 1)); // long length
    pending_keys.push_back(make_key('h61, 0, 1, "a", 0));           // legacy release
    pending_keys.push_back(make_key('hffe1, 1, 0, 0, 1));           // bare modifier
    pending_keys.push_back(make_key('h1fffffff, 0, 4, 32'h0, 1));
    drain_encoder();

    // Application cursor mode.
    apb_write(AddrAppCursor, 1);
    pending_keys.push_back(make_key('hff50, 0, 0, 0, 1));
    pending_keys.push_back(make_key('hff57, 0, 0, 0, 1));
    drain_encoder();

    // Progressive protocol with associated text.
    apb_write(AddrProtocolFlags, 31);
    pending_keys.push_back(make_key('h20ac, 3, 3, 32'h00ac82e2, 1)); // euro sign
    pending_keys.push_back(make_key('h1234, 0, 2, 32'h000080c3, 0)); // release
    pending_keys.push_back(make_key('h1234, 0, 2, 32'h000041c3, 1)); // bad UTF-8
    pending_keys.push_back(make_key('h1234, 0, 4, 32'h0, 1));        // zero text byte
    pending_keys.push_back(make_key('h1234, 0, 0, 0, 1));            // dead key
    pending_keys.push_back(make_key('hff52, 0, 0, 0, 0));
    pending_keys.push_back(make_key(KsReturn, 0, 0, 0, 1));
    pending_keys.push_back(make_key('h1f600, 15, 4, 32'h80989ff0, 1));
    drain_encoder();

    // Random phases, including register extremes.
    for (int phase = 0; phase < 6; phase++) begin
      apb_write(AddrProtocolFlags, (phase == 0) ? 0 : (phase == 1) ? 31 :
                (phase == 2) ? 1 : $urandom_range(31, 0));
      apb_write(AddrAppCursor, phase % 2);
      for (int i = 0; i < 45; i++) pending_keys.push_back(random_key());
      if (phase == 3) hold_off = 300;
      drain_encoder();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/kese_pkg.sv
hw/rtl/kese_front.sv
hw/rtl/kese_queue.sv
hw/rtl/kese_back.sv
hw/rtl/keystroke_escape_sequence_encoder.sv
dv/keystroke_escape_sequence_encoder_tb.sv
